FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the checker file sid_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check that a condition implies another in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg
// Codes, limits and the button code table of the serial input decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sid_pkg;

  localparam int BUTTONS             = 30;
  localparam int WHEEL_TICKS_PER_REV = 15;
  localparam int BALL_TICKS_PER_REV  = 164;
  localparam int COUNT_W             = 24;

  localparam logic [7:0] ACK_BYTE       = 8'hFC;
  localparam logic [7:0] RELEASE_OFFSET = 8'h30;
  localparam logic [7:0] WHEEL_UP       = 8'hE0;
  localparam logic [7:0] WHEEL_DOWN     = 8'hE1;
  localparam logic [7:0] NORTH_UP       = 8'hF2;
  localparam logic [7:0] NORTH_DOWN     = 8'hF3;
  localparam logic [7:0] EAST_UP        = 8'hF0;
  localparam logic [7:0] EAST_DOWN      = 8'hF1;

  localparam logic [7:0] PRESS_CODE [BUTTONS] = '{
    8'h89, 8'h88, 8'h90, 8'h8e, 8'h8d, 8'h8c, 8'h8b, 8'h8a, 8'h9b, 8'h9a,
    8'h99, 8'h98, 8'h9f, 8'h9e, 8'h9d, 8'h9c, 8'h81, 8'h80, 8'h8f, 8'h86,
    8'h85, 8'h84, 8'h83, 8'h82, 8'ha0, 8'h87, 8'ha1, 8'ha2, 8'h92, 8'h91
  };

  localparam logic [1:0] CFG_POLL    = 2'd0;
  localparam logic [1:0] CFG_SILENCE = 2'd1;
  localparam logic [1:0] CFG_WAIT    = 2'd2;

  localparam logic [1:0] MODE_OUT_RESET = 2'd0;
  localparam logic [1:0] MODE_OUT_WAIT  = 2'd1;
  localparam logic [1:0] MODE_OUT_SYNC  = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DECODED  = 3'd1,
    EV_IGNORED  = 3'd2,
    EV_UNKNOWN  = 3'd3,
    EV_NO_REPLY = 3'd4,
    EV_BAD_REPLY = 3'd5,
    EV_SILENCE  = 3'd6
  } event_t;

  typedef enum logic [2:0] {
    MODE_RESET = 3'b001,
    MODE_WAIT  = 3'b010,
    MODE_SYNC  = 3'b100
  } mode_t;

  typedef struct packed {
    logic       press;
    logic       release_hit;
    logic [4:0] btn;
    logic       wheel;
    logic       north;
    logic       east;
    logic       down;
    logic       ignore;
  } dec_t;

endpackage

`default_nettype wire

FILE: rtl/sid_decode.sv
// ----------------------------------------------------------------------------
// sid_decode
// Classifies one received byte: button press or release, dial step, ignored, or none.
// ----------------------------------------------------------------------------
`default_nettype none

module sid_decode
  import sid_pkg::*;
(
  input  wire logic [7:0] rx_byte,
  output dec_t            dec
);

  always_comb begin
    dec = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      if (rx_byte == PRESS_CODE[i]) begin
        dec.press = 1'b1;
        dec.btn   = 5'(i);
      end
      if (rx_byte == 8'(PRESS_CODE[i] + RELEASE_OFFSET)) begin
        dec.release_hit = 1'b1;
        dec.btn         = 5'(i);
      end
    end
    case (rx_byte)
      WHEEL_UP: dec.wheel = 1'b1;
      WHEEL_DOWN: begin
        dec.wheel = 1'b1;
        dec.down  = 1'b1;
      end
      NORTH_UP: dec.north = 1'b1;
      NORTH_DOWN: begin
        dec.north = 1'b1;
        dec.down  = 1'b1;
      end
      EAST_UP: dec.east = 1'b1;
      EAST_DOWN: begin
        dec.east = 1'b1;
        dec.down = 1'b1;
      end
      default: dec.ignore = rx_byte inside {8'h00, 8'h10, 8'hFB, 8'hFC, 8'hFD, 8'hFE};
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/orb_serial_input_decoder_top.sv
// ----------------------------------------------------------------------------
// orb_serial_input_decoder_top
// Handshake, button and dial decoder for a byte-per-event serial input device.
// ----------------------------------------------------------------------------
// Each input beat is a received byte (cmd 0) or a millisecond tick (cmd 1) and
// yields exactly one result beat showing the state after that beat. A beat
// waits in the input register until its result is registered on the output;
// one beat is taken every cycle while out_stall holds no result, and
// in_stall rises only while a result is held by out_stall and the input
// register is full. The decode of one beat is a single pass of compare and
// increment logic; the state registers double as the result payload.
`default_nettype none

module orb_serial_input_decoder_top
  import sid_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [COUNT_W-1:0]  cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                cmd,
  input  wire logic [7:0]          rx_byte,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [BUTTONS-1:0]       button_bits,
  output logic signed [31:0]       wheel_dial,
  output logic signed [31:0]       north_dial,
  output logic signed [31:0]       east_dial,
  output logic signed [4:0]        wheel_level,
  output logic signed [8:0]        north_level,
  output logic signed [8:0]        east_level,
  output logic                     send_request,
  output logic [1:0]               mode,
  output logic [2:0]               event_res
);

  localparam logic signed [4:0] WHEEL_LIM = 5'(WHEEL_TICKS_PER_REV);
  localparam logic signed [8:0] BALL_LIM  = 9'(BALL_TICKS_PER_REV);

  function automatic logic signed [4:0] step_wheel(logic signed [4:0] lvl, logic down);
    if (!down) return (lvl >= WHEEL_LIM) ? WHEEL_LIM : lvl + 5'sd1;
    return (lvl <= -WHEEL_LIM) ? -WHEEL_LIM : lvl - 5'sd1;
  endfunction

  function automatic logic signed [8:0] step_ball(logic signed [8:0] lvl, logic down);
    if (!down) return (lvl >= BALL_LIM) ? BALL_LIM : lvl + 9'sd1;
    return (lvl <= -BALL_LIM) ? -BALL_LIM : lvl - 9'sd1;
  endfunction

  logic [COUNT_W-1:0] poll_ticks;
  logic [COUNT_W-1:0] silence_limit_ticks;
  logic [COUNT_W-1:0] response_wait_ticks;

  logic               s1_valid;
  logic               s1_cmd;
  logic [7:0]         s1_byte;
  logic               advance;

  mode_t              mode_state;
  mode_t              mode_next;
  logic [COUNT_W-1:0] silence_count;
  logic [COUNT_W-1:0] silence_next;
  logic [COUNT_W-1:0] wait_count;
  logic [COUNT_W-1:0] wait_next;
  logic [BUTTONS-1:0] buttons_next;
  logic signed [31:0] wheel_dial_next;
  logic signed [31:0] north_dial_next;
  logic signed [31:0] east_dial_next;
  logic signed [4:0]  wheel_level_next;
  logic signed [8:0]  north_level_next;
  logic signed [8:0]  east_level_next;
  logic               req_next;
  event_t             ev_next;
  dec_t               dec;

  sid_decode u_decode (
    .rx_byte (s1_byte),
    .dec     (dec)
  );

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_ticks          <= COUNT_W'(5000);
      silence_limit_ticks <= COUNT_W'(10000);
      response_wait_ticks <= COUNT_W'(2000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLL:    poll_ticks          <= cfg_data;
        CFG_SILENCE: silence_limit_ticks <= cfg_data;
        CFG_WAIT:    response_wait_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd  <= cmd;
      s1_byte <= rx_byte;
    end
  end

  always_comb begin
    mode_next        = mode_state;
    silence_next     = silence_count;
    wait_next        = wait_count;
    buttons_next     = button_bits;
    wheel_dial_next  = wheel_dial;
    north_dial_next  = north_dial;
    east_dial_next   = east_dial;
    wheel_level_next = wheel_level;
    north_level_next = north_level;
    east_level_next  = east_level;
    req_next         = 1'b0;
    ev_next          = EV_NONE;
    case (mode_state)
      MODE_WAIT: begin
        if (s1_cmd) begin
          if (wait_count != '1) wait_next = wait_count + 1'b1;
          if (wait_next >= response_wait_ticks) begin
            mode_next = MODE_RESET;
            ev_next   = EV_NO_REPLY;
          end
        end else if (s1_byte == ACK_BYTE) begin
          mode_next    = MODE_SYNC;
          silence_next = '0;
        end else begin
          mode_next = MODE_RESET;
          ev_next   = EV_BAD_REPLY;
        end
      end
      MODE_SYNC: begin
        if (s1_cmd) begin
          if (silence_count != '1) silence_next = silence_count + 1'b1;
          req_next = silence_next > poll_ticks;
          if (silence_next > silence_limit_ticks) begin
            mode_next = MODE_RESET;
            ev_next   = EV_SILENCE;
          end
        end else begin
          silence_next = '0;
          ev_next      = EV_DECODED;
          if (dec.press) begin
            buttons_next[dec.btn] = 1'b1;
          end else if (dec.release_hit) begin
            buttons_next[dec.btn] = 1'b0;
          end else if (dec.wheel) begin
            wheel_dial_next  = dec.down ? wheel_dial - 32'sd1 : wheel_dial + 32'sd1;
            wheel_level_next = step_wheel(wheel_level, dec.down);
          end else if (dec.north) begin
            north_dial_next  = dec.down ? north_dial - 32'sd1 : north_dial + 32'sd1;
            north_level_next = step_ball(north_level, dec.down);
          end else if (dec.east) begin
            east_dial_next  = dec.down ? east_dial - 32'sd1 : east_dial + 32'sd1;
            east_level_next = step_ball(east_level, dec.down);
          end else if (dec.ignore) begin
            ev_next = EV_IGNORED;
          end else begin
            ev_next   = EV_UNKNOWN;
            mode_next = MODE_RESET;
          end
        end
      end
      default: begin
        if (s1_cmd) begin
          buttons_next     = '0;
          wheel_dial_next  = '0;
          north_dial_next  = '0;
          east_dial_next   = '0;
          wheel_level_next = '0;
          north_level_next = '0;
          east_level_next  = '0;
          req_next         = 1'b1;
          wait_next        = '0;
          mode_next        = MODE_WAIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state    <= MODE_RESET;
      silence_count <= '0;
      wait_count    <= '0;
      button_bits   <= '0;
      wheel_dial    <= '0;
      north_dial    <= '0;
      east_dial     <= '0;
      wheel_level   <= '0;
      north_level   <= '0;
      east_level    <= '0;
      send_request  <= 1'b0;
      event_res     <= EV_NONE;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        mode_state    <= mode_next;
        silence_count <= silence_next;
        wait_count    <= wait_next;
        button_bits   <= buttons_next;
        wheel_dial    <= wheel_dial_next;
        north_dial    <= north_dial_next;
        east_dial     <= east_dial_next;
        wheel_level   <= wheel_level_next;
        north_level   <= north_level_next;
        east_level    <= east_level_next;
        send_request  <= req_next;
        event_res     <= ev_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    case (mode_state)
      MODE_WAIT: mode = MODE_OUT_WAIT;
      MODE_SYNC: mode = MODE_OUT_SYNC;
      default:   mode = MODE_OUT_RESET;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/sid_checker.sv
// ----------------------------------------------------------------------------
// sid_checker
// Port-level checks of the serial input decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sid_checker
  import sid_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              send_request,
  input wire logic [1:0]        mode,
  input wire logic [2:0]        event_res,
  input wire logic signed [4:0] wheel_level
);

  logic req_ok;
  logic fail_ev;
  logic decode_ev;
  logic wheel_ok;

  assign req_ok    = mode != MODE_OUT_RESET || event_res == EV_SILENCE;
  assign fail_ev   = event_res == EV_UNKNOWN || event_res == EV_NO_REPLY ||
                     event_res == EV_BAD_REPLY || event_res == EV_SILENCE;
  assign decode_ev = event_res == EV_DECODED || event_res == EV_IGNORED;
  assign wheel_ok  = wheel_level <= 5'(WHEEL_TICKS_PER_REV) &&
                     wheel_level >= -5'(WHEEL_TICKS_PER_REV);

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")
  `ASSERT_IMPLIES(a_req_mode, out_valid && send_request, req_ok, "request raised in reset mode")
  `ASSERT_IMPLIES(a_fail_mode, out_valid && fail_ev, mode == MODE_OUT_RESET, "failure outside reset")
  `ASSERT_IMPLIES(a_decode_mode, out_valid && decode_ev, mode == MODE_OUT_SYNC, "decode outside sync")
  `ASSERT_IMPLIES(a_wheel_sat, out_valid, wheel_ok, "wheel level beyond saturation limit")

endmodule

bind orb_serial_input_decoder_top sid_checker u_sid_checker (.*);

`default_nettype wire

FILE: tb/sv/orb_serial_input_decoder_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// orb_serial_input_decoder_top_test
// Self-checking bench for the serial input decoder. A scripted opening walks
// the handshake, its timeout and bad reply, three presses and a release, every
// dial code, the ignored and unknown codes and the silence poll and timeout.
// Random sessions follow, under several register settings from zero to the
// 24-bit maximum, with long dial sweeps that drive the levels into saturation.
// Every result beat is checked against a cycle-free model of the decoder state.
// ----------------------------------------------------------------------------
module orb_serial_input_decoder_top_test;
  import sid_pkg::*;

  localparam int          RESET_CYCLES = 11;
  localparam int          DRAIN_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          PHASES       = 6;
  localparam int          PHASE_BEATS  = 175;
  localparam int          SWEEP_STEPS  = 168;
  localparam int          WHEEL_STEPS  = 20;

  localparam logic [23:0] DEF_POLL    = 24'd5000;
  localparam logic [23:0] DEF_SILENCE = 24'd10000;
  localparam logic [23:0] DEF_WAIT    = 24'd2000;
  localparam logic [23:0] MAX24       = 24'hFF_FFFF;

  localparam logic [7:0] STRAY_CODE = 8'hFF;
  localparam logic [7:0] FILLER_CODES [6] = '{8'h00, 8'h10, 8'hFB, ACK_BYTE, 8'hFD, 8'hFE};
  localparam logic [7:0] DIAL_CODES [6] =
    '{WHEEL_UP, WHEEL_DOWN, NORTH_UP, NORTH_DOWN, EAST_UP, EAST_DOWN};
  localparam logic [1:0] REG_ORDER [3] = '{CFG_POLL, CFG_SILENCE, CFG_WAIT};

  // poll, silence limit, reply wait; row 0 serves the scripted opening
  localparam logic [23:0] PHASE_CFG [PHASES+1][3] = '{
    '{24'd2,  24'd4,  24'd2},
    '{24'd3,  24'd8,  24'd3},
    '{24'd1,  24'd1,  24'd1},
    '{24'd0,  24'd0,  24'd0},
    '{24'd6,  24'd12, 24'd5},
    '{MAX24,  MAX24,  MAX24},
    '{24'd20, 24'd10, 24'd7}
  };

  typedef struct packed {
    logic       tick;
    logic [7:0] data;
    logic       pinned;
    logic [1:0] mode;
    event_t     ev;
  } script_row_t;

  localparam int SCRIPT_LEN = 28;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{1'b0, STRAY_CODE,      1'b1, MODE_OUT_RESET, EV_NONE},
    '{1'b1, STRAY_CODE,      1'b1, MODE_OUT_WAIT,  EV_NONE},
    '{1'b1, STRAY_CODE,      1'b0, MODE_OUT_WAIT,  EV_NONE},
    '{1'b1, STRAY_CODE,      1'b1, MODE_OUT_RESET, EV_NO_REPLY},
    '{1'b1, STRAY_CODE,      1'b1, MODE_OUT_WAIT,  EV_NONE},
    '{1'b0, FILLER_CODES[0], 1'b1, MODE_OUT_RESET, EV_BAD_REPLY},
    '{1'b1, STRAY_CODE,      1'b0, MODE_OUT_WAIT,  EV_NONE},
    '{1'b0, ACK_BYTE,        1'b1, MODE_OUT_SYNC,  EV_NONE},
    '{1'b0, PRESS_CODE[16],  1'b1, MODE_OUT_SYNC,  EV_DECODED},
    '{1'b0, PRESS_CODE[0],   1'b0, MODE_OUT_SYNC,  EV_DECODED},
    '{1'b0, PRESS_CODE[29],  1'b0, MODE_OUT_SYNC,  EV_DECODED},
    '{1'b0, PRESS_CODE[16] + RELEASE_OFFSET, 1'b0, MODE_OUT_SYNC, EV_DECODED},
    '{1'b0, WHEEL_UP,        1'b0, MODE_OUT_SYNC,  EV_DECODED},
    '{1'b0, WHEEL_DOWN,      1'b0, MODE_OUT_SYNC,  EV_DECODED},
    '{1'b0, NORTH_UP,        1'b0, MODE_OUT_SYNC,  EV_DECODED},
    '{1'b0, NORTH_DOWN,      1'b0, MODE_OUT_SYNC,  EV_DECODED},
    '{1'b0, EAST_UP,         1'b0, MODE_OUT_SYNC,  EV_DECODED},
    '{1'b0, EAST_DOWN,       1'b0, MODE_OUT_SYNC,  EV_DECODED},
    '{1'b0, FILLER_CODES[1], 1'b1, MODE_OUT_SYNC,  EV_IGNORED},
    '{1'b0, ACK_BYTE,        1'b1, MODE_OUT_SYNC,  EV_IGNORED},
    '{1'b1, STRAY_CODE,      1'b0, MODE_OUT_SYNC,  EV_NONE},
    '{1'b1, STRAY_CODE,      1'b0, MODE_OUT_SYNC,  EV_NONE},
    '{1'b1, STRAY_CODE,      1'b0, MODE_OUT_SYNC,  EV_NONE},
    '{1'b1, STRAY_CODE,      1'b0, MODE_OUT_SYNC,  EV_NONE},
    '{1'b1, STRAY_CODE,      1'b1, MODE_OUT_RESET, EV_SILENCE},
    '{1'b1, STRAY_CODE,      1'b1, MODE_OUT_WAIT,  EV_NONE},
    '{1'b0, ACK_BYTE,        1'b1, MODE_OUT_SYNC,  EV_NONE},
    '{1'b0, STRAY_CODE,      1'b1, MODE_OUT_RESET, EV_UNKNOWN}
  };

  typedef struct packed {
    logic [BUTTONS-1:0] buttons;
    logic [31:0]        wheel_dial;
    logic [31:0]        north_dial;
    logic [31:0]        east_dial;
    logic [4:0]         wheel_level;
    logic [8:0]         north_level;
    logic [8:0]         east_level;
    logic               send_request;
    logic [1:0]         mode;
    event_t             ev;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_POLL;
  logic [COUNT_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               cmd = 1'b0;
  logic [7:0]         rx_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [BUTTONS-1:0] button_bits;
  logic signed [31:0] wheel_dial;
  logic signed [31:0] north_dial;
  logic signed [31:0] east_dial;
  logic signed [4:0]  wheel_level;
  logic signed [8:0]  north_level;
  logic signed [8:0]  east_level;
  logic               send_request;
  logic [1:0]         mode;
  logic [2:0]         event_res;

  // scripted mode and event that travel with a beat
  logic       pin_on = 1'b0;
  logic [1:0] pin_mode = MODE_OUT_RESET;
  event_t     pin_ev = EV_NONE;

  bit          calm = 1'b0;
  int          beats_sent = 0;
  int          errors = 0;
  int unsigned cycle_cnt = 0;
  reading_t    outstanding [$];

  // decoder state
  logic [1:0]         sync_mode;
  logic [BUTTONS-1:0] held_buttons;
  logic [31:0]        dial_cnt [3];
  int                 wheel_lvl;
  int                 ball_lvl [2];
  logic [23:0]        quiet_cnt;
  logic [23:0]        reply_cnt;
  logic [23:0]        poll_lim;
  logic [23:0]        quiet_lim;
  logic [23:0]        reply_lim;

  orb_serial_input_decoder_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .button_bits  (button_bits),
    .wheel_dial   (wheel_dial),
    .north_dial   (north_dial),
    .east_dial    (east_dial),
    .wheel_level  (wheel_level),
    .north_level  (north_level),
    .east_level   (east_level),
    .send_request (send_request),
    .mode         (mode),
    .event_res    (event_res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void clear_readings();
    held_buttons = '0;
    dial_cnt = '{32'd0, 32'd0, 32'd0};
    wheel_lvl = 0;
    ball_lvl = '{0, 0};
  endfunction

  function automatic int step_level(input int lvl, input bit up, input int lim);
    if (up) return (lvl >= lim) ? lim : lvl + 1;
    return (lvl <= -lim) ? -lim : lvl - 1;
  endfunction

  function automatic reading_t predict_beat(input logic tick, input logic [7:0] data);
    reading_t r;
    logic     req;
    event_t   ev;
    bit       hit;
    bit       up;
    int       axis;
    int       i;
    req = 1'b0;
    ev = EV_NONE;
    hit = 1'b0;
    case (sync_mode)
      MODE_OUT_WAIT: begin
        if (tick) begin
          if (reply_cnt != MAX24) reply_cnt++;
          if (reply_cnt >= reply_lim) begin
            sync_mode = MODE_OUT_RESET;
            ev = EV_NO_REPLY;
          end
        end else if (data == ACK_BYTE) begin
          sync_mode = MODE_OUT_SYNC;
          quiet_cnt = '0;
        end else begin
          sync_mode = MODE_OUT_RESET;
          ev = EV_BAD_REPLY;
        end
      end
      MODE_OUT_SYNC: begin
        if (tick) begin
          if (quiet_cnt != MAX24) quiet_cnt++;
          if (quiet_cnt > poll_lim) req = 1'b1;
          if (quiet_cnt > quiet_lim) begin
            sync_mode = MODE_OUT_RESET;
            ev = EV_SILENCE;
          end
        end else begin
          quiet_cnt = '0;
          ev = EV_DECODED;
          for (i = 0; i < BUTTONS && !hit; i++) begin
            if (data == PRESS_CODE[i]) begin
              held_buttons[i] = 1'b1;
              hit = 1'b1;
            end else if (data == PRESS_CODE[i] + RELEASE_OFFSET) begin
              held_buttons[i] = 1'b0;
              hit = 1'b1;
            end
          end
          if (!hit) begin
            case (data)
              WHEEL_UP, WHEEL_DOWN: begin
                up = (data == WHEEL_UP);
                dial_cnt[0] = up ? dial_cnt[0] + 1 : dial_cnt[0] - 1;
                wheel_lvl = step_level(wheel_lvl, up, WHEEL_TICKS_PER_REV);
              end
              NORTH_UP, NORTH_DOWN, EAST_UP, EAST_DOWN: begin
                axis = (data == NORTH_UP || data == NORTH_DOWN) ? 0 : 1;
                up = (data == NORTH_UP || data == EAST_UP);
                dial_cnt[axis+1] = up ? dial_cnt[axis+1] + 1 : dial_cnt[axis+1] - 1;
                ball_lvl[axis] = step_level(ball_lvl[axis], up, BALL_TICKS_PER_REV);
              end
              default: begin
                ev = EV_UNKNOWN;
                for (i = 0; i < 6; i++) begin
                  if (data == FILLER_CODES[i]) ev = EV_IGNORED;
                end
                if (ev == EV_UNKNOWN) sync_mode = MODE_OUT_RESET;
              end
            endcase
          end
        end
      end
      default: begin
        sync_mode = MODE_OUT_RESET;
        if (tick) begin
          clear_readings();
          req = 1'b1;
          reply_cnt = '0;
          sync_mode = MODE_OUT_WAIT;
        end
      end
    endcase
    r.buttons = held_buttons;
    r.wheel_dial = dial_cnt[0];
    r.north_dial = dial_cnt[1];
    r.east_dial = dial_cnt[2];
    r.wheel_level = wheel_lvl[4:0];
    r.north_level = ball_lvl[0][8:0];
    r.east_level = ball_lvl[1][8:0];
    r.send_request = req;
    r.mode = sync_mode;
    r.ev = ev;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    reading_t want;
    if (rst) begin
      poll_lim = DEF_POLL;
      quiet_lim = DEF_SILENCE;
      reply_lim = DEF_WAIT;
      sync_mode = MODE_OUT_RESET;
      clear_readings();
      quiet_cnt = '0;
      reply_cnt = '0;
      outstanding.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POLL:    poll_lim = cfg_data;
          CFG_SILENCE: quiet_lim = cfg_data;
          CFG_WAIT:    reply_lim = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (outstanding.size() == 0) begin
          $error("result beat with no beat pending");
          errors++;
        end else begin
          want = outstanding.pop_front();
          check_field("button_bits", want.buttons, button_bits);
          check_field("wheel_dial", want.wheel_dial, wheel_dial);
          check_field("north_dial", want.north_dial, north_dial);
          check_field("east_dial", want.east_dial, east_dial);
          check_field("wheel_level", want.wheel_level, $unsigned(wheel_level));
          check_field("north_level", want.north_level, $unsigned(north_level));
          check_field("east_level", want.east_level, $unsigned(east_level));
          check_field("send_request", want.send_request, send_request);
          check_field("mode", want.mode, mode);
          check_field("event_res", want.ev, event_res);
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_beat(cmd, rx_byte);
        if (pin_on) begin
          want.mode = pin_mode;
          want.ev = pin_ev;
        end
        outstanding.push_back(want);
      end
    end
  end

  initial begin : stall_gen
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        n = $urandom_range(0, 40);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic tick, input logic [7:0] data);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= tick;
    rx_byte <= data;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic tick_burst(input int n);
    repeat (n) send_beat(1'b1, 8'($urandom));
  endtask

  task automatic noise_burst(input int n);
    repeat (n) send_beat(1'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int p);
    int r;
    drain();
    for (r = 0; r < 3; r++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_ORDER[r];
      cfg_data <= PHASE_CFG[p][r];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_session(input int len);
    int         k;
    int         pick;
    int         run;
    logic [7:0] code;
    send_beat(1'b0, FILLER_CODES[0]);
    send_beat(1'b1, 8'($urandom));
    send_beat(1'b0, ACK_BYTE);
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        code = PRESS_CODE[$urandom_range(0, BUTTONS-1)];
        send_beat(1'b0, $urandom_range(0, 1) ? code + RELEASE_OFFSET : code);
      end else if (pick < 65) begin
        code = DIAL_CODES[$urandom_range(0, 5)];
        run = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 30) : 1;
        repeat (run) send_beat(1'b0, code);
      end else if (pick < 75) begin
        send_beat(1'b0, FILLER_CODES[$urandom_range(0, 5)]);
      end else if (pick < 92) begin
        tick_burst($urandom_range(1, 3));
      end else begin
        send_beat(1'b0, 8'($urandom));
      end
    end
  endtask

  // force a fresh handshake, then push every level past its limit
  task automatic level_sweep(input bit up);
    int k;
    send_beat(1'b0, STRAY_CODE);
    send_beat(1'b1, 8'($urandom));
    send_beat(1'b0, ACK_BYTE);
    repeat (WHEEL_STEPS) send_beat(1'b0, up ? WHEEL_UP : WHEEL_DOWN);
    for (k = 0; k < SWEEP_STEPS; k++) begin
      send_beat(1'b0, up ? NORTH_UP : NORTH_DOWN);
      send_beat(1'b0, up ? EAST_UP : EAST_DOWN);
    end
  endtask

  initial begin : stimulus
    int k;
    int p;
    int pick;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    configure(0);
    for (k = 0; k < SCRIPT_LEN; k++) begin
      pin_on <= SCRIPT[k].pinned;
      pin_mode <= SCRIPT[k].mode;
      pin_ev <= SCRIPT[k].ev;
      send_beat(SCRIPT[k].tick, SCRIPT[k].data);
    end
    pin_on <= 1'b0;
    for (p = 1; p <= PHASES; p++) begin
      configure(p);
      calm = (p == PHASES);
      if (p == 1 || p == 4) level_sweep(p == 1);
      do begin
        pick = $urandom_range(0, 9);
        if (pick < 7) run_session($urandom_range(4, 40));
        else if (pick < 9) tick_burst($urandom_range(1, 24));
        else noise_burst($urandom_range(1, 10));
      end while (beats_sent < SCRIPT_LEN + p * PHASE_BEATS);
    end
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
